@@ hw/rtl/lcats_pkg.sv @@
// lcats_pkg: shared widths, codes and types for the load-cell average/tare/scale block.
// No dependencies; imported by every module of the block.

package lcats_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 8;
    localparam int SCALE_W  = 32;
    localparam int UNITS_W  = 48;
    localparam int DIFF_W   = SAMPLE_W + 1;

    // shared divider: 65-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIVD_W = DIFF_W + 32;
    localparam int DIVS_W = SCALE_W;
    localparam int STEP_W = 7;

    localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] UNITS_STEPS = STEP_W'(DIVD_W);

    localparam logic [1:0] KIND_WEIGH  = 2'd0;
    localparam logic [1:0] KIND_TARE   = 2'd1;
    localparam logic [1:0] KIND_OFFSET = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_SCALE        = 1'b1;

    localparam logic [CNT_W-1:0]   SAMPLE_COUNT_RST = 8'd1;
    localparam logic [SCALE_W-1:0] SCALE_RST        = 32'h0001_0000;

    typedef enum logic [1:0] {
        ST_WEIGHED    = 2'd0,
        ST_TARE       = 2'd1,
        ST_OFFSET     = 2'd2,
        ST_SCALE_ZERO = 2'd3
    } t_status;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctrl;

endpackage

@@ hw/rtl/load_cell_average_tare_scale_top.sv @@
// load_cell_average_tare_scale_top: batch averaging, tare and Q16.16 scaling of load-cell data.
// Depends on lcats_pkg and lcats_div (shared iterative divider).
//
// Usage:
//   Input stream (s_axis): tdata = raw signed sample (or new offset), tuser = kind.
//     kind 0 weighing sample, 1 tare sample, 2 load offset, 3 ignored.
//   Output stream (m_axis): tdata = {average, units_q16}, tuser = status.
//   Config channel (i_cfg_*): index 0 sample_count, index 1 scale_q16; write only when idle.
// Samples of kind 0/1 accumulate in a 40-bit sum; the one that completes the batch decides
// whether it weighs or tares. Path of each input transfer:
//   sample that does not end a batch: accumulated, ready again at once
//   offset load: new offset stored, result goes out through S_DONE
//   tare batch or zero scale: 40-step average divide (S_LOAD_AVG, S_AVG), then S_DONE
//   weighing batch: 40-step average divide plus 65-step units divide, then S_DONE
// The single shared divider does both divides; S_DONE waits while the output register is full.
// s_axis_tready stays low meanwhile and rises in the same cycle as m_axis_tvalid.
// A finished result sits in the output register; if the receiver stalls, the block still
// takes samples that do not end a batch and waits only when a new result has nowhere to go.
// Synchronous active-low reset clears the batch, offset, config (count 1, scale 1.0) and
// the output valid.

module load_cell_average_tare_scale_top import lcats_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // [31:0] sample
    input  logic [1:0]            s_axis_tuser,  // [1:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata,  // [47:0] units_q16, [79:48] average
    output logic [1:0]            m_axis_tuser,  // [1:0] status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_index,
    input  logic [SCALE_W-1:0]    i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_LOAD_AVG   = 7'b0000010,
        S_AVG        = 7'b0000100,
        S_DIFF       = 7'b0001000,
        S_LOAD_UNITS = 7'b0010000,
        S_UNITS      = 7'b0100000,
        S_DONE       = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // control state
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_offset;
    logic [CNT_W-1:0]    r_sample_count;
    logic [SCALE_W-1:0]  r_scale;
    logic                r_m_tvalid;

    // datapath holding registers
    logic                r_tare;
    logic                r_avg_neg;
    logic                r_units_neg;
    logic [SAMPLE_W-1:0] r_avg;
    logic [DIFF_W-1:0]   r_diff;
    logic [UNITS_W-1:0]  r_res_units;
    logic [SAMPLE_W-1:0] r_res_avg;
    t_status             r_res_status;
    logic [UNITS_W-1:0]  r_m_units;
    logic [SAMPLE_W-1:0] r_m_avg;
    t_status             r_m_status;

    logic                w_in_xfer;
    logic                w_out_free;
    logic [SUM_W-1:0]    w_sum_next;
    logic [CNT_W-1:0]    w_cnt_next;
    logic [CNT_W-1:0]    w_need;
    logic                w_batch_end;
    logic [SUM_W-1:0]    w_sum_abs;
    logic [DIFF_W-1:0]   w_diff_abs;
    logic [SCALE_W-1:0]  w_scale_abs;
    logic [SAMPLE_W-1:0] w_avg;
    logic                w_q_big;
    logic [UNITS_W-1:0]  w_mag;
    logic [UNITS_W-1:0]  w_units;

    t_div_ctrl           w_div_ctrl;
    logic [DIVD_W-1:0]   w_div_dividend;
    logic [DIVS_W-1:0]   w_div_divisor;
    logic                w_div_done;
    logic [DIVD_W-1:0]   w_div_quot;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_xfer     = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_m_tvalid | m_axis_tready;

    always_comb begin
        w_sum_next  = r_sum + {{(SUM_W-SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata};
        w_cnt_next  = r_cnt + 1'b1;
        w_need      = (r_sample_count == '0) ? CNT_W'(1) : r_sample_count;
        w_batch_end = (w_cnt_next >= w_need);
        w_sum_abs   = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
        w_diff_abs  = r_diff[DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
        w_scale_abs = r_scale[SCALE_W-1] ? (~r_scale + 1'b1) : r_scale;
        // average magnitude is at most 2^31, so 32 bits hold it
        w_avg = r_avg_neg ? (~w_div_quot[SAMPLE_W-1:0] + 1'b1) : w_div_quot[SAMPLE_W-1:0];
        // saturate the quotient magnitude: 2^47-1 when positive, 2^47 when negative
        w_q_big = |w_div_quot[DIVD_W-1:UNITS_W];
        if (r_units_neg) begin
            w_mag = (w_q_big | (w_div_quot[UNITS_W-1] & (|w_div_quot[UNITS_W-2:0])))
                  ? {1'b1, {(UNITS_W-1){1'b0}}} : w_div_quot[UNITS_W-1:0];
            w_units = ~w_mag + 1'b1;
        end else begin
            w_mag = (w_q_big | w_div_quot[UNITS_W-1])
                  ? {1'b0, {(UNITS_W-1){1'b1}}} : w_div_quot[UNITS_W-1:0];
            w_units = w_mag;
        end
    end

    // divider request
    always_comb begin
        w_div_ctrl.start = 1'b0;
        w_div_ctrl.steps = AVG_STEPS;
        w_div_dividend   = {w_sum_abs, {(DIVD_W-SUM_W){1'b0}}};
        w_div_divisor    = {{(DIVS_W-CNT_W){1'b0}}, r_cnt};
        case (r_state)
            S_LOAD_AVG: begin
                w_div_ctrl.start = 1'b1;
            end
            S_LOAD_UNITS: begin
                w_div_ctrl.start = 1'b1;
                w_div_ctrl.steps = UNITS_STEPS;
                w_div_dividend   = {w_diff_abs, {(DIVD_W-DIFF_W){1'b0}}};
                w_div_divisor    = w_scale_abs;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tuser == KIND_OFFSET) begin
                        n_state = S_DONE;
                    end else if (s_axis_tuser != KIND_NONE && w_batch_end) begin
                        n_state = S_LOAD_AVG;
                    end
                end
            end
            S_LOAD_AVG: n_state = S_AVG;
            S_AVG: begin
                if (w_div_done) begin
                    if (r_tare || r_scale == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF:       n_state = S_LOAD_UNITS;
            S_LOAD_UNITS: n_state = S_UNITS;
            S_UNITS: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sum          <= '0;
            r_cnt          <= '0;
            r_offset       <= '0;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_scale        <= SCALE_RST;
            r_m_tvalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SAMPLE_COUNT) begin
                    r_sample_count <= i_cfg_data[CNT_W-1:0];
                end else begin
                    r_scale <= i_cfg_data;
                end
            end
            if (w_in_xfer) begin
                if (s_axis_tuser == KIND_OFFSET) begin
                    r_offset <= s_axis_tdata;
                end else if (s_axis_tuser != KIND_NONE) begin
                    r_sum <= w_sum_next;
                    r_cnt <= w_cnt_next;
                end
            end
            if (r_state == S_LOAD_AVG) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (r_state == S_AVG && w_div_done && r_tare) begin
                r_offset <= w_avg;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_tare       <= (s_axis_tuser == KIND_TARE);
            r_res_units  <= '0;
            r_res_avg    <= '0;
            r_res_status <= ST_OFFSET;
        end
        if (r_state == S_LOAD_AVG) begin
            r_avg_neg <= r_sum[SUM_W-1];
        end
        if (r_state == S_AVG && w_div_done) begin
            r_avg       <= w_avg;
            r_res_avg   <= w_avg;
            r_res_units <= '0;
            if (r_tare) begin
                r_res_status <= ST_TARE;
            end else begin
                r_res_status <= ST_SCALE_ZERO;
            end
        end
        if (r_state == S_DIFF) begin
            r_diff <= {r_avg[SAMPLE_W-1], r_avg} - {r_offset[SAMPLE_W-1], r_offset};
        end
        if (r_state == S_LOAD_UNITS) begin
            r_units_neg <= r_diff[DIFF_W-1] ^ r_scale[SCALE_W-1];
        end
        if (r_state == S_UNITS && w_div_done) begin
            r_res_units  <= w_units;
            r_res_status <= ST_WEIGHED;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_m_units  <= r_res_units;
            r_m_avg    <= r_res_avg;
            r_m_status <= r_res_status;
        end
    end

    lcats_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {r_m_avg, r_m_units};
    assign m_axis_tuser  = r_m_status;

endmodule

@@ hw/rtl/lcats_div.sv @@
// lcats_div: shared restoring divider, one quotient bit per cycle.
// Depends on lcats_pkg. Dividend must be left-aligned so that 'steps' bits cover it.

module lcats_div import lcats_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctrl         i_ctrl,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);

    logic [STEP_W-1:0] r_steps;
    logic              r_done;
    logic [DIVS_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quot;
    logic [DIVS_W-1:0] r_div;

    logic [DIVS_W:0]   w_trial;
    logic [DIVS_W+1:0] w_sub;
    logic              w_ge;
    logic [DIVS_W:0]   n_rem;
    logic [DIVD_W-1:0] n_quot;

    always_comb begin
        w_trial = {r_rem[DIVS_W-1:0], r_quot[DIVD_W-1]};
        w_sub   = {1'b0, w_trial} - {2'b00, r_div};
        w_ge    = ~w_sub[DIVS_W+1];
        n_rem   = w_ge ? w_sub[DIVS_W:0] : w_trial;
        n_quot  = {r_quot[DIVD_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            // done pulses the cycle after the last step
            r_done <= ~i_ctrl.start & (r_steps == STEP_W'(1));
            if (i_ctrl.start) begin
                r_steps <= i_ctrl.steps;
            end else if (r_steps != '0) begin
                r_steps <= r_steps - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_steps != '0) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hw/rtl/lcats_checker.sv @@
// lcats_port_checks: port-level assertions for load_cell_average_tare_scale_top, plus its bind.
// Depends on lcats_pkg; attached to the top level by the bind at the end of this file.

module lcats_port_checks import lcats_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output result changed while stalled");

    // an offset load always produces a result, so the block leaves idle
    a_offset_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_OFFSET |=> !s_axis_tready)
        else $error("offset load did not start a result");

    // ignored kind leaves the block idle
    a_none_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_NONE |=> s_axis_tready)
        else $error("ignored kind made the block busy");

    // only a weighing result carries units
    a_units_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_WEIGHED |-> m_axis_tdata[47:0] == '0)
        else $error("nonzero units on a non-weighing result");

    // an offset load reports no average
    a_offset_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OFFSET |-> m_axis_tdata[79:48] == '0)
        else $error("nonzero average on an offset load result");

endmodule

bind load_cell_average_tare_scale_top lcats_port_checks u_lcats_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
